// ===== rtl/pee_pkg.sv =====
// Shared types and constants for the postfix expression evaluator.
// Character codes, default sizes and the result record.
// No dependencies.
package pee_pkg;

  // Default sizes
  localparam int unsigned DEF_STACK_DEPTH = 64;
  localparam int unsigned DEF_VALUE_WIDTH = 32;

  // Width of the delivered top value
  localparam int unsigned RESULT_W = 32;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_MUL   = 8'd42;
  localparam logic [7:0] CH_SUB   = 8'd45;
  localparam logic [7:0] CH_ADD   = 8'd43;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_NL    = 8'd10;

  // One result item
  typedef struct packed {
    logic signed [RESULT_W-1:0] top_value;
    logic                       overflow_seen;
  } result_t;

endpackage

// ===== rtl/pee_char_if.sv =====
// Input channel: one character byte per item, valid/ready handshake.
// Depends on nothing.
interface pee_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

// ===== rtl/pee_result_if.sv =====
// Output channel: top value and sticky overflow flag, valid/ready handshake.
// Depends on nothing.
interface pee_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] top_value;
  logic               overflow_seen;

  modport source (output valid, output top_value, output overflow_seen, input ready);
  modport sink (input valid, input top_value, input overflow_seen, output ready);
endinterface

// ===== rtl/pee_stack_mem.sv =====
// Operand store: single-port-write, single-port-read synchronous RAM.
// Read data is registered and holds until the next read.
// Depends on nothing.
module pee_stack_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/pee_out_buf.sv =====
// Two-entry output buffer (output register plus skid) for result items.
// Depends on pee_pkg and pee_result_if.
module pee_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pee_pkg::result_t push_data,
  output logic             can_push,
  pee_result_if.source     result_out
);

  import pee_pkg::*;

  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;

  assign can_push                 = !skid_valid;
  assign result_out.valid         = out_valid;
  assign result_out.top_value     = out_data.top_value;
  assign result_out.overflow_seen = out_data.overflow_seen;

  // Control: advance the output register when it is free or taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || result_out.ready) begin
      out_valid  <= skid_valid || push;
      skid_valid <= skid_valid && push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (!out_valid || result_out.ready) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (push) begin
          skid_data <= push_data;
        end
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// ===== rtl/postfix_expression_evaluator_unit.sv =====
// Postfix expression evaluator: one character item accepted per cycle while
// the output buffer has room. Top of stack and next entry live in registers;
// deeper entries sit in a synchronous RAM with registered read, refilled by
// one read after an operator when an entry remains below. A newline pushes
// a result item into the output buffer. Synchronous reset empties the stack,
// clears overflow flag and output buffer; the RAM needs no clearing pass.
module postfix_expression_evaluator_unit #(
  parameter int unsigned STACK_DEPTH = pee_pkg::DEF_STACK_DEPTH,
  parameter int unsigned VALUE_WIDTH = pee_pkg::DEF_VALUE_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  pee_char_if.sink    char_in,
  pee_result_if.source result_out
);

  import pee_pkg::*;

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] ONE  = CW'(1);
  localparam logic [CW-1:0] TWO  = CW'(2);
  localparam logic [CW-1:0] THREE = CW'(3);

  // Stack state
  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;
  logic [VALUE_WIDTH-1:0] top;
  logic [VALUE_WIDTH-1:0] top_next;
  logic [VALUE_WIDTH-1:0] second;
  logic [VALUE_WIDTH-1:0] second_next;
  logic                   second_pend;
  logic                   second_pend_next;
  logic                   ovf;
  logic                   ovf_next;

  // RAM side
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic [VALUE_WIDTH-1:0] rd_data;

  // Operator datapath
  logic [VALUE_WIDTH-1:0] second_eff;
  logic [VALUE_WIDTH-1:0] opa;
  logic [VALUE_WIDTH-1:0] opb;
  logic [VALUE_WIDTH-1:0] op_res;
  logic [VALUE_WIDTH-1:0] digit;
  logic [CW-1:0]          wr_idx;
  logic [CW-1:0]          rd_idx;

  // Output side
  logic    accept;
  logic    can_push;
  logic    res_push;
  result_t res_data;

  assign accept        = char_in.valid && char_in.ready;
  assign char_in.ready = can_push;

  // Second entry comes from RAM read data right after an operator
  assign second_eff = second_pend ? rd_data : second;
  assign opa        = (count >= ONE) ? top : '0;
  assign opb        = (count >= TWO) ? second_eff : '0;
  assign digit      = VALUE_WIDTH'(char_in.char_code) - VALUE_WIDTH'(CH_ZERO);
  assign wr_idx     = count - TWO;
  assign rd_idx     = count - THREE;
  assign wr_addr    = wr_idx[AW-1:0];
  assign rd_addr    = rd_idx[AW-1:0];

  // Apply the operator: second op top
  always_comb begin
    case (char_in.char_code) inside
      CH_MUL:  op_res = opb * opa;
      CH_SUB:  op_res = opb - opa;
      default: op_res = opb + opa;
    endcase
  end

  // Decode the character and update the stack
  always_comb begin
    count_next       = count;
    top_next         = top;
    second_next      = second;
    second_pend_next = second_pend;
    ovf_next         = ovf;
    wr_en            = 1'b0;
    rd_en            = 1'b0;
    res_push         = 1'b0;
    res_data.top_value     = (count != '0) ? RESULT_W'($signed(top)) : '0;
    res_data.overflow_seen = ovf;
    if (accept) begin
      case (char_in.char_code) inside
        CH_NL: begin
          res_push         = 1'b1;
          count_next       = '0;
          second_pend_next = 1'b0;
        end
        CH_SPACE: begin
        end
        CH_MUL, CH_SUB, CH_ADD: begin
          top_next = op_res;
          if (count >= TWO) begin
            count_next = count - ONE;
          end else begin
            count_next = ONE;
          end
          // Refill the second entry from RAM when one remains below it
          if (count >= THREE) begin
            rd_en            = 1'b1;
            second_pend_next = 1'b1;
          end else begin
            second_pend_next = 1'b0;
          end
        end
        default: begin
          if (count == FULL) begin
            ovf_next = 1'b1;
          end else begin
            top_next   = digit;
            count_next = count + ONE;
            // Spill the second entry into RAM, drop top into second
            if (count >= TWO) begin
              wr_en = 1'b1;
            end
            if (count >= ONE) begin
              second_next      = top;
              second_pend_next = 1'b0;
            end
          end
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      second_pend <= 1'b0;
      ovf         <= 1'b0;
    end else begin
      count       <= count_next;
      second_pend <= second_pend_next;
      ovf         <= ovf_next;
    end
  end

  // Cached stack entries
  always_ff @(posedge clk) begin
    top    <= top_next;
    second <= second_next;
  end

  pee_stack_mem #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (VALUE_WIDTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (second_eff),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pee_out_buf u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (res_push),
    .push_data  (res_data),
    .can_push   (can_push),
    .result_out (result_out)
  );

endmodule
